// File: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Combinational invariant, checked at every clock edge out of reset.
`define CHK_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Same-cycle implication.
`define CHK_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/gas_pkg.sv
`timescale 1ns / 1ps

package gas_pkg;

  localparam int GRID_SIDE = 64;
  localparam int CELLS     = GRID_SIDE * GRID_SIDE;
  localparam int CELL_W    = 12;
  localparam int LEN_W     = 13;
  localparam int G_W       = 13;
  localparam int F_W       = 22;
  localparam int H_W       = 17;
  localparam int ND_W      = 20;
  localparam int SQ_W      = 34;
  localparam int SQ_STEPS  = 17;

  localparam logic [G_W-1:0]   G_MAX    = 13'h1FFF;
  localparam logic [F_W-1:0]   F_MAX    = 22'h3FFFFF;
  localparam logic [LEN_W-1:0] CELLS_CT = 13'd4096;

  localparam logic [1:0] REQ_WRITE  = 2'd0;
  localparam logic [1:0] REQ_SEARCH = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_PARTIAL = 2'd1,
    ST_ERR     = 2'd2
  } status_t;

  typedef struct packed {
    logic           closed;
    logic [G_W-1:0] g;
    logic [F_W-1:0] f;
  } node_t;

endpackage

// File: rtl/grid_astar_path_search_top.sv
`timescale 1ns / 1ps
// A* search on a 64x64 grid, 4-connected, unit step cost, Euclidean heuristic.
// Input channel (in_valid / in_stall) takes one request per transfer:
//   write cell, start search, read a stored path point, or an idle
//   code. Each request yields exactly one result transfer on the output
//   channel (out_valid / out_stall) with last status, path length and point.
// Search: a clearing pass of the node memory, then per expansion the pick,
//   the open-list scan (one entry per cycle through the open-list and node
//   memories) and the pop, plus up to 4 neighbors (a bit-serial square
//   root each), then the parent-chain walk over the path points.
// One request is in flight at a time; in_stall is high while it runs.
// The result register lets a request be taken while the previous result
//   still waits; a held result stalls only the finishing step.
// Reset: a pass over every cell clears the blocked map while in_stall stays
//   high; the stored status and length start at zero.
`include "assert_macros.svh"

module grid_astar_path_search_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] req_type,
  input  logic [5:0] cell_row,
  input  logic [5:0] cell_col,
  input  logic       cell_blocked,
  input  logic signed [8:0] dest_row,
  input  logic signed [8:0] dest_col,
  input  logic [11:0] path_index,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] status,
  output logic [12:0] path_length,
  output logic [5:0] point_row,
  output logic [5:0] point_col
);
  import gas_pkg::*;

  typedef enum logic [17:0] {
    S_INIT  = 18'h00001,
    S_IDLE  = 18'h00002,
    S_SRC   = 18'h00004,
    S_CLR   = 18'h00008,
    S_SEED  = 18'h00010,
    S_PICK  = 18'h00020,
    S_SCAN  = 18'h00040,
    S_POP   = 18'h00080,
    S_POPW  = 18'h00100,
    S_NB    = 18'h00200,
    S_NCHK  = 18'h00400,
    S_HWAIT = 18'h00800,
    S_TRACE = 18'h01000,
    S_TCHK  = 18'h02000,
    S_PREAD = 18'h04000,
    S_PCAP  = 18'h08000,
    S_FIN   = 18'h10000,
    S_SPARE = 18'h20000
  } state_t;

  state_t state;

  // memories
  logic              blk_mem [CELLS];
  node_t             node_mem [CELLS];
  logic [CELL_W-1:0] par_mem [CELLS];
  logic [CELL_W-1:0] open_mem [CELLS];
  logic [CELL_W-1:0] path_mem [CELLS];

  logic              blk_we, blk_wd, blk_q;
  logic [CELL_W-1:0] blk_wa, blk_ra;
  logic              node_we;
  node_t             node_wd, node_q;
  logic [CELL_W-1:0] node_wa, node_ra;
  logic              par_we;
  logic [CELL_W-1:0] par_wa, par_wd, par_ra, par_q;
  logic              open_we;
  logic [CELL_W-1:0] open_wa, open_wd, open_ra, open_q;
  logic              path_we;
  logic [CELL_W-1:0] path_wa, path_wd, path_ra, path_q;

  always_ff @(posedge clk) begin
    if (blk_we) blk_mem[blk_wa] <= blk_wd;
    blk_q <= blk_mem[blk_ra];
  end
  always_ff @(posedge clk) begin
    if (node_we) node_mem[node_wa] <= node_wd;
    node_q <= node_mem[node_ra];
  end
  always_ff @(posedge clk) begin
    if (par_we) par_mem[par_wa] <= par_wd;
    par_q <= par_mem[par_ra];
  end
  always_ff @(posedge clk) begin
    if (open_we) open_mem[open_wa] <= open_wd;
    open_q <= open_mem[open_ra];
  end
  always_ff @(posedge clk) begin
    if (path_we) path_mem[path_wa] <= path_wd;
    path_q <= path_mem[path_ra];
  end

  // registers
  logic [5:0]        src_row, src_col;
  logic signed [8:0] dst_r, dst_c;
  logic [11:0]       idx;
  logic [11:0]       clr;
  logic [LEN_W-1:0]  count;
  logic [CELL_W-1:0] cur;
  logic [G_W-1:0]    cur_g;
  logic [F_W-1:0]    cur_f;
  logic [LEN_W-1:0]  scan_i;
  logic              s1_v, s2_v;
  logic [11:0]       s1_i, s2_i;
  logic [CELL_W-1:0] s2_cell;
  logic [11:0]       best_i;
  logic [CELL_W-1:0] best_cell;
  logic [G_W-1:0]    best_g;
  logic [F_W:0]      best_f;
  logic [1:0]        dir;
  logic [CELL_W-1:0] n_cell;
  logic [G_W-1:0]    n_g;
  logic [F_W-1:0]    old_f;
  logic [CELL_W-1:0] nearest;
  logic [ND_W-1:0]   ndist;
  logic [CELL_W-1:0] tcur;
  logic [LEN_W-1:0]  tk;
  status_t           tst;
  status_t           st;
  logic [LEN_W-1:0]  len;
  logic [CELL_W-1:0] pt;

  // square root unit
  logic [SQ_W-1:0]   sq_rem, sq_root, sq_bit;
  logic [4:0]        sq_cnt;
  logic              sq_start, sq_done;
  logic [5:0]        sq_r, sq_c;
  logic signed [9:0] dx, dy;
  logic [8:0]        ax, ay;
  logic [17:0]       sq_sum;
  logic [SQ_W-1:0]   sq_trial;
  logic [H_W-1:0]    h;

  assign sq_done  = (sq_cnt == 5'd0);
  assign h        = sq_root[H_W-1:0];
  assign sq_trial = sq_root + sq_bit;

  always_comb begin
    dx = $signed({4'b0, sq_r}) - $signed({dst_r[8], dst_r});
    dy = $signed({4'b0, sq_c}) - $signed({dst_c[8], dst_c});
    ax = dx[9] ? 9'(-dx) : dx[8:0];
    ay = dy[9] ? 9'(-dy) : dy[8:0];
    sq_sum = 18'({9'b0, ax} * {9'b0, ax}) + 18'({9'b0, ay} * {9'b0, ay});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_cnt <= '0;
    end else if (sq_start) begin
      sq_rem  <= SQ_W'({sq_sum, 16'b0});
      sq_root <= '0;
      sq_bit  <= SQ_W'(1) << 32;
      sq_cnt  <= 5'(SQ_STEPS);
    end else if (!sq_done) begin
      if (sq_rem >= sq_trial) begin
        sq_rem  <= sq_rem - sq_trial;
        sq_root <= (sq_root >> 1) + sq_bit;
      end else begin
        sq_root <= sq_root >> 1;
      end
      sq_bit <= sq_bit >> 2;
      sq_cnt <= sq_cnt - 5'd1;
    end
  end

  // neighbor geometry
  logic signed [6:0] nb_r, nb_c;
  logic              nb_in, nb_dest;
  logic [CELL_W-1:0] nb_cell;
  logic [G_W-1:0]    g_inc;
  logic [F_W:0]      f_sum;
  logic [F_W-1:0]    f_new;
  logic              src_is_dest;
  logic              accept;
  logic              out_free;
  logic              scan_end;

  always_comb begin
    nb_r = $signed({1'b0, cur[11:6]});
    nb_c = $signed({1'b0, cur[5:0]});
    case (dir)
      2'd0:    nb_r = nb_r - 7'sd1;
      2'd1:    nb_c = nb_c - 7'sd1;
      2'd2:    nb_r = nb_r + 7'sd1;
      default: nb_c = nb_c + 7'sd1;
    endcase
    nb_in   = !nb_r[6] && !nb_c[6];
    nb_cell = {nb_r[5:0], nb_c[5:0]};
    nb_dest = (dst_r == $signed({3'b0, nb_r[5:0]})) && (dst_c == $signed({3'b0, nb_c[5:0]}));
    g_inc   = (cur_g == G_MAX) ? G_MAX : cur_g + 13'd1;
    f_sum   = (F_W+1)'({n_g, 8'b0}) + (F_W+1)'(h);
    f_new   = (f_sum > (F_W+1)'(F_MAX)) ? F_MAX : f_sum[F_W-1:0];
    src_is_dest = (dst_r == $signed({3'b0, src_row})) && (dst_c == $signed({3'b0, src_col}));
  end

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign scan_end = (scan_i == count) && !s1_v && !s2_v;

  // memory port control
  always_comb begin
    blk_we  = 1'b0; blk_wa = {cell_row, cell_col}; blk_wd = cell_blocked;
    blk_ra  = {cell_row, cell_col};
    node_we = 1'b0; node_wa = n_cell; node_wd = '{closed: 1'b0, g: n_g, f: f_new};
    node_ra = nb_cell;
    par_we  = 1'b0; par_wa = n_cell; par_wd = cur; par_ra = tcur;
    open_we = 1'b0; open_wa = count[11:0]; open_wd = n_cell;
    open_ra = scan_i[11:0];
    path_we = 1'b0; path_wa = tk[11:0]; path_wd = tcur;
    path_ra = 12'(len - 13'd1 - {1'b0, idx});
    sq_start = 1'b0; sq_r = src_row; sq_c = src_col;
    unique case (state)
      S_INIT: begin
        blk_we = 1'b1; blk_wa = clr; blk_wd = 1'b0;
      end
      S_IDLE: begin
        blk_we = accept && (req_type == REQ_WRITE);
      end
      S_SRC: begin
        sq_start = !blk_q && !src_is_dest;
      end
      S_CLR: begin
        node_we = 1'b1; node_wa = clr;
        node_wd = '{closed: 1'b0, g: G_MAX, f: F_MAX};
      end
      S_SEED: begin
        node_we = sq_done; node_wa = {src_row, src_col};
        node_wd = '{closed: 1'b0, g: '0, f: '0};
        par_we  = sq_done; par_wa = {src_row, src_col}; par_wd = {src_row, src_col};
        open_we = sq_done; open_wa = '0; open_wd = {src_row, src_col};
      end
      S_SCAN: begin
        node_ra = open_q;
      end
      S_POP: begin
        open_ra = 12'(count - 13'd1);
        node_we = 1'b1; node_wa = cur;
        node_wd = '{closed: 1'b1, g: cur_g, f: cur_f};
      end
      S_POPW: begin
        open_we = 1'b1; open_wa = best_i; open_wd = open_q;
      end
      S_NB: begin
        blk_ra = nb_cell;
        par_we = nb_in && nb_dest; par_wa = nb_cell;
      end
      S_NCHK: begin
        sq_start = !node_q.closed && !blk_q;
        sq_r = n_cell[11:6]; sq_c = n_cell[5:0];
      end
      S_HWAIT: begin
        node_we = sq_done && (f_new < old_f);
        par_we  = sq_done && (f_new < old_f);
        open_we = sq_done && (f_new < old_f) && (old_f == F_MAX) && (count != CELLS_CT);
      end
      S_TRACE: begin
        path_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      clr       <= '0;
      count     <= '0;
      nearest   <= '0;
      ndist     <= '0;
      len       <= '0;
      st        <= ST_OK;
      out_valid <= 1'b0;
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_FIN) out_valid <= 1'b0;
      unique case (state)
        S_INIT: begin
          clr <= clr + 12'd1;
          if (clr == 12'hFFF) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            src_row <= cell_row;
            src_col <= cell_col;
            dst_r   <= dest_row;
            dst_c   <= dest_col;
            idx     <= path_index;
            pt      <= '0;
            case (req_type)
              REQ_SEARCH: state <= S_SRC;
              REQ_READ:   state <= ({1'b0, path_index} < len) ? S_PREAD : S_FIN;
              default:    state <= S_FIN;
            endcase
          end
        end
        S_SRC: begin
          if (blk_q) begin
            st <= ST_ERR; len <= '0; state <= S_FIN;
          end else if (src_is_dest) begin
            st <= ST_OK; len <= '0; state <= S_FIN;
          end else begin
            clr <= '0; state <= S_CLR;
          end
        end
        S_CLR: begin
          clr <= clr + 12'd1;
          if (clr == 12'hFFF) state <= S_SEED;
        end
        S_SEED: begin
          if (sq_done) begin
            count   <= 13'd1;
            nearest <= {src_row, src_col};
            ndist   <= ND_W'(h);
            state   <= S_PICK;
          end
        end
        S_PICK: begin
          if (count == '0) begin
            tcur <= nearest; tst <= ST_PARTIAL; tk <= '0; state <= S_TRACE;
          end else begin
            scan_i <= '0; s1_v <= 1'b0; s2_v <= 1'b0;
            best_i <= '0; best_f <= '1;
            state  <= S_SCAN;
          end
        end
        S_SCAN: begin
          s1_v <= (scan_i != count);
          s1_i <= scan_i[11:0];
          if (scan_i != count) scan_i <= scan_i + 13'd1;
          s2_v    <= s1_v;
          s2_i    <= s1_i;
          s2_cell <= open_q;
          if (s2_v && ({1'b0, node_q.f} < best_f)) begin
            best_f    <= {1'b0, node_q.f};
            best_i    <= s2_i;
            best_cell <= s2_cell;
            best_g    <= node_q.g;
          end
          if (scan_end) begin
            cur   <= best_cell;
            cur_g <= best_g;
            cur_f <= best_f[F_W-1:0];
            state <= S_POP;
          end
        end
        S_POP: begin
          count <= count - 13'd1;
          state <= S_POPW;
        end
        S_POPW: begin
          dir   <= 2'd0;
          state <= S_NB;
        end
        S_NB: begin
          n_cell <= nb_cell;
          if (!nb_in) begin
            dir <= dir + 2'd1;
            if (dir == 2'd3) state <= S_PICK;
          end else if (nb_dest) begin
            tcur <= nb_cell; tst <= ST_OK; tk <= '0; state <= S_TRACE;
          end else begin
            state <= S_NCHK;
          end
        end
        S_NCHK: begin
          if (node_q.closed || blk_q) begin
            dir <= dir + 2'd1;
            state <= (dir == 2'd3) ? S_PICK : S_NB;
          end else begin
            n_g   <= g_inc;
            old_f <= node_q.f;
            state <= S_HWAIT;
          end
        end
        S_HWAIT: begin
          if (sq_done) begin
            if (ND_W'(h) < ndist) begin
              ndist <= ND_W'(h); nearest <= n_cell;
            end
            if ((f_new < old_f) && (old_f == F_MAX) && (count == CELLS_CT)) begin
              st <= ST_ERR; len <= '0; state <= S_FIN;
            end else begin
              if ((f_new < old_f) && (old_f == F_MAX)) count <= count + 13'd1;
              dir <= dir + 2'd1;
              state <= (dir == 2'd3) ? S_PICK : S_NB;
            end
          end
        end
        S_TRACE: begin
          state <= S_TCHK;
        end
        S_TCHK: begin
          if (par_q == tcur) begin
            len <= tk + 13'd1; st <= tst; state <= S_FIN;
          end else if (tk == 13'd4095) begin
            len <= '0; st <= ST_ERR; state <= S_FIN;
          end else begin
            tcur <= par_q; tk <= tk + 13'd1; state <= S_TRACE;
          end
        end
        S_PREAD: begin
          state <= S_PCAP;
        end
        S_PCAP: begin
          pt    <= path_q;
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            status      <= st;
            path_length <= len;
            point_row   <= pt[11:6];
            point_col   <= pt[5:0];
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CHK_ALWAYS(a_count_max, count <= CELLS_CT, "open count beyond grid size")
  `CHK_IMPLY(a_scan_nonempty, state == S_SCAN, count != '0, "scan with empty open list")
  `CHK_IMPLY(a_read_in_range, state == S_PREAD, {1'b0, idx} < len, "path read out of range")
  `CHK_NEXT(a_accept_busy, accept, state != S_IDLE, "request taken but block idle")

endmodule

// File: dv/grid_astar_path_search_checker.sv
`timescale 1ns / 1ps

module grid_astar_path_search_checker
  import gas_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [1:0]        req_type,
  input  logic [5:0]        cell_row,
  input  logic [5:0]        cell_col,
  input  logic              cell_blocked,
  input  logic signed [8:0] dest_row,
  input  logic signed [8:0] dest_col,
  input  logic [11:0]       path_index,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [1:0]        status,
  input  logic [12:0]       path_length,
  input  logic [5:0]        point_row,
  input  logic [5:0]        point_col,
  output int                fail_count,
  output int                pending
);

  typedef struct packed {
    logic [1:0]  status;
    logic [12:0] length;
    logic [5:0]  row;
    logic [5:0]  col;
  } answer_t;

  bit          blk_map [CELLS];
  bit          done_map[CELLS];
  int unsigned g_cost  [CELLS];
  int unsigned f_cost  [CELLS];
  int unsigned parent  [CELLS];
  int unsigned frontier[CELLS];
  int unsigned route   [CELLS];
  int unsigned frontier_n, near_cell, near_dist, route_len;
  status_t     last_status;
  answer_t     answers_q[$];

  function automatic int unsigned euclid_q8(int r, int c, int dr, int dc);
    longint unsigned v, res, b;
    longint signed dx, dy;
    dx = r - dr;
    dy = c - dc;
    v = longint'(dx * dx + dy * dy) * 65536;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else res = res >> 1;
      b = b >> 2;
    end
    return int'(res);
  endfunction

  function automatic void walk_back(int unsigned target, status_t st);
    int unsigned cnt, cur;
    cnt = 1;
    cur = target;
    while (parent[cur] != cur) begin
      cur = parent[cur];
      if (cur >= CELLS || cnt >= CELLS) begin
        last_status = ST_ERR;
        route_len = 0;
        return;
      end
      cnt++;
    end
    cur = target;
    for (int k = cnt; k > 0; k--) begin
      route[k-1] = cur;
      cur = parent[cur];
    end
    route_len = cnt;
    last_status = st;
  endfunction

  function automatic void run_search(int sr, int sc, int dr, int dc);
    int unsigned src, best, bestf, cur, n, g, h, f;
    int row, col, nr, nc;
    bit listed;
    src = sr * GRID_SIDE + sc;
    if (blk_map[src]) begin
      last_status = ST_ERR;
      route_len = 0;
      return;
    end
    if (sr == dr && sc == dc) begin
      last_status = ST_OK;
      route_len = 0;
      return;
    end
    for (int i = 0; i < CELLS; i++) begin
      done_map[i] = 0;
      g_cost[i] = G_MAX;
      f_cost[i] = F_MAX;
    end
    g_cost[src] = 0;
    f_cost[src] = 0;
    parent[src] = src;
    frontier[0] = src;
    frontier_n = 1;
    near_cell = src;
    near_dist = euclid_q8(sr, sc, dr, dc);
    while (frontier_n > 0) begin
      best = 0;
      bestf = 32'hFFFF_FFFF;
      for (int i = 0; i < frontier_n; i++)
        if (f_cost[frontier[i]] < bestf) begin
          bestf = f_cost[frontier[i]];
          best = i;
        end
      cur = frontier[best];
      frontier_n--;
      frontier[best] = frontier[frontier_n];
      row = cur / GRID_SIDE;
      col = cur % GRID_SIDE;
      done_map[cur] = 1;
      for (int k = 0; k < 4; k++) begin
        nr = row + ((k == 0) ? -1 : (k == 2) ? 1 : 0);
        nc = col + ((k == 1) ? -1 : (k == 3) ? 1 : 0);
        if (nr < 0 || nr >= GRID_SIDE || nc < 0 || nc >= GRID_SIDE) continue;
        n = nr * GRID_SIDE + nc;
        if (nr == dr && nc == dc) begin
          parent[n] = cur;
          walk_back(n, ST_OK);
          return;
        end
        if (done_map[n] || blk_map[n]) continue;
        g = g_cost[cur] + 1;
        if (g > G_MAX) g = G_MAX;
        h = euclid_q8(nr, nc, dr, dc);
        if (h < near_dist) begin
          near_dist = h;
          near_cell = n;
        end
        f = g * 256 + h;
        if (f > F_MAX) f = F_MAX;
        if (f < f_cost[n]) begin
          f_cost[n] = f;
          g_cost[n] = g;
          parent[n] = cur;
          listed = 0;
          for (int i = 0; i < frontier_n; i++)
            if (frontier[i] == n) begin
              listed = 1;
              break;
            end
          if (!listed) begin
            if (frontier_n >= CELLS) begin
              last_status = ST_ERR;
              route_len = 0;
              return;
            end
            frontier[frontier_n++] = n;
          end
        end
      end
    end
    walk_back(near_cell, ST_PARTIAL);
  endfunction

  function automatic answer_t apply_request();
    answer_t a;
    a = '0;
    if (req_type == REQ_WRITE)
      blk_map[cell_row * GRID_SIDE + cell_col] = cell_blocked;
    else if (req_type == REQ_SEARCH)
      run_search(cell_row, cell_col, int'(dest_row), int'(dest_col));
    else if (req_type == REQ_READ && path_index < route_len) begin
      a.row = 6'(route[path_index] / GRID_SIDE);
      a.col = 6'(route[path_index] % GRID_SIDE);
    end
    a.status = last_status;
    a.length = 13'(route_len);
    return a;
  endfunction

  assign pending = answers_q.size();

  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      foreach (blk_map[i]) blk_map[i] = 0;
      route_len = 0;
      last_status = ST_OK;
      fail_count <= 0;
      answers_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (answers_q.size() == 0) begin
          $display("%0t: unexpected result transfer status=%0d len=%0d", $time,
                   status, path_length);
          fail_count <= fail_count + 1;
        end else begin
          want = answers_q.pop_front();
          if (want !== {status, path_length, point_row, point_col}) begin
            $display("%0t: mismatch exp st=%0d len=%0d pt=(%0d,%0d)",
                     $time, want.status, want.length, want.row, want.col);
            $display("%0t:          got st=%0d len=%0d pt=(%0d,%0d)",
                     $time, status, path_length, point_row, point_col);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall) answers_q.push_back(apply_request());
    end
  end

endmodule

// File: dv/grid_astar_path_search_top_tb.sv
`timescale 1ns / 1ps

module grid_astar_path_search_top_tb;
  import gas_pkg::*;

  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam int ARENA = 6;
  localparam int RAND_ITEMS = 66;
  localparam int CYCLE_LIMIT = 3000000;

  logic              clk = 0;
  logic              rst = 1;
  logic              in_valid = 0;
  logic              in_stall;
  logic [1:0]        req_type = REQ_WRITE;
  logic [5:0]        cell_row = 0;
  logic [5:0]        cell_col = 0;
  logic              cell_blocked = 0;
  logic signed [8:0] dest_row = 0;
  logic signed [8:0] dest_col = 0;
  logic [11:0]       path_index = 0;
  logic              out_valid;
  logic              out_stall = 0;
  logic [1:0]        status;
  logic [12:0]       path_length;
  logic [5:0]        point_row;
  logic [5:0]        point_col;
  int                fail_count, pending, cycles, stall_cnt, sent;
  bit                quiet;

  always #5 clk = ~clk;

  grid_astar_path_search_top u_top (.*);

  grid_astar_path_search_checker u_chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 0;
      stall_cnt <= 0;
    end else if (stall_cnt != 0) begin
      stall_cnt <= stall_cnt - 1;
      out_stall <= 1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_cnt <= $urandom_range(0, 13);
      out_stall <= 1;
    end else out_stall <= 0;
  end

  task automatic send(logic [1:0] rq, int r, int c, bit b, int dr, int dc, int idx);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    req_type <= rq;
    cell_row <= 6'(r);
    cell_col <= 6'(c);
    cell_blocked <= b;
    dest_row <= 9'(dr);
    dest_col <= 9'(dc);
    path_index <= 12'(idx);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic find(int r, int c, int dr, int dc);
    send(REQ_SEARCH, r, c, $urandom_range(0, 1), dr, dc, $urandom);
  endtask

  task automatic put(int r, int c, bit b);
    send(REQ_WRITE, r, c, b, $urandom, $urandom, $urandom);
  endtask

  task automatic fetch(int idx);
    send(REQ_READ, $urandom, $urandom, $urandom_range(0, 1), $urandom, $urandom, idx);
  endtask

  initial begin
    int kind, r, c, dr, dc;
    repeat (10) @(posedge clk);
    rst <= 0;
    // small walled pocket in the corner keeps exhaustive searches short
    for (int i = 0; i <= ARENA; i++) put(ARENA, i, 1);
    for (int i = 0; i < ARENA; i++) put(i, ARENA, 1);
    fetch(0);
    send(REQ_NONE, 63, 63, 1, -1, -1, 4095);
    find(63, 63, 63, 63);
    put(63, 63, 1);
    find(63, 63, 60, 63);
    put(63, 63, 0);
    find(40, 40, 44, 47);
    fetch(0);
    fetch(5);
    fetch(10);
    fetch(4095);
    find(0, 0, -128, -128);
    fetch(3);
    find(5, 5, 191, 191);
    find(0, 0, ARENA, 2);
    put(2, 2, 1);
    find(0, 0, 4, 4);
    put(32, 32, 1);
    find(31, 32, 32, 32);
    find(63, 0, 62, 0);
    find(0, 63, 1, 63);
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n > RAND_ITEMS * 4 / 5) quiet = 1;
      kind = $urandom_range(0, 99);
      if (kind < 33)
        put($urandom_range(0, ARENA - 1), $urandom_range(0, ARENA - 1),
            $urandom_range(0, 9) < 4);
      else if (kind < 38) put($urandom_range(20, 63), $urandom_range(20, 63), 0);
      else if (kind < 68) begin
        if ($urandom_range(0, 9) < 7) begin
          r = $urandom_range(0, ARENA - 1);
          c = $urandom_range(0, ARENA - 1);
          if ($urandom_range(0, 6) == 0) begin
            dr = $urandom_range(0, 319) - 128;
            dc = $urandom_range(0, 319) - 128;
          end else begin
            dr = $urandom_range(0, ARENA + 3) - 2;
            dc = $urandom_range(0, ARENA + 3) - 2;
          end
        end else begin
          r = $urandom_range(10, 63);
          c = $urandom_range(10, 63);
          dr = r + $urandom_range(0, 16) - 8;
          dc = c + $urandom_range(0, 16) - 8;
          if (dr < 9) dr = 9;
          if (dr > 63) dr = 63;
          if (dc < 9) dc = 9;
          if (dc > 63) dc = 63;
        end
        find(r, c, dr, dc);
      end else if (kind < 96)
        fetch(($urandom_range(0, 9) < 8) ? $urandom_range(0, 15) : $urandom_range(0, 4095));
      else send(REQ_NONE, $urandom, $urandom, $urandom_range(0, 1), $urandom, $urandom,
                $urandom);
    end
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Covered %0d requests: cell writes, searches inside a walled pocket and", sent);
    $display("in open grid, path point reads and idle codes, with random gaps and stalls.");
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
